[sv/olr_pkg.sv]
`timescale 1ns / 1ps
// Shared types and codes for the octant line rasterizer.
package olr_pkg;

  // Request opcodes
  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  // Eight line zones; ZONE0 is the reference zone 0 <= dy < dx
  typedef enum logic [2:0] {
    ZONE0, ZONE1, ZONE2, ZONE3, ZONE4, ZONE5, ZONE6, ZONE7
  } zone_e;

endpackage

[sv/olr_setup.sv]
`timescale 1ns / 1ps
// Line setup: zone classification, mapping into zone 0 and decision terms.
module olr_setup import olr_pkg::*; #(
  parameter int COORD_BITS = 12
) (
  input  logic signed [COORD_BITS-1:0] x_start_i,
  input  logic signed [COORD_BITS-1:0] y_start_i,
  input  logic signed [COORD_BITS-1:0] x_end_i,
  input  logic signed [COORD_BITS-1:0] y_end_i,
  output logic signed [COORD_BITS:0]   walk_x_o,
  output logic signed [COORD_BITS:0]   walk_y_o,
  output logic signed [COORD_BITS:0]   walk_end_x_o,
  output logic signed [COORD_BITS+2:0] decision_o,
  output logic signed [COORD_BITS+2:0] step_east_o,
  output logic signed [COORD_BITS+2:0] step_diagonal_o,
  output zone_e                        zone_o,
  output logic                         active_o
);

  localparam int WalkW = COORD_BITS + 1;
  localparam int DecW  = COORD_BITS + 3;

  logic signed [WalkW-1:0] xs, ys, xe, ye, dx, dy;
  logic        [WalkW-1:0] adx, ady, major, minor;
  logic signed [DecW-1:0]  maj_w, min_w;
  logic                    x_major;

  assign xs = WalkW'(x_start_i);
  assign ys = WalkW'(y_start_i);
  assign xe = WalkW'(x_end_i);
  assign ye = WalkW'(y_end_i);
  assign dx = xe - xs;
  assign dy = ye - ys;

  assign adx = dx[WalkW-1] ? WalkW'(-dx) : WalkW'(dx);
  assign ady = dy[WalkW-1] ? WalkW'(-dy) : WalkW'(dy);
  assign x_major = adx > ady;

  always_comb begin
    case ({dx[WalkW-1], dy[WalkW-1]})
      2'b00:   zone_o = x_major ? ZONE0 : ZONE1;
      2'b01:   zone_o = x_major ? ZONE7 : ZONE6;
      2'b11:   zone_o = x_major ? ZONE4 : ZONE5;
      default: zone_o = x_major ? ZONE3 : ZONE2;
    endcase
  end

  // Start point and end x folded into zone 0
  always_comb begin
    unique case (zone_o)
      ZONE1: begin walk_x_o = ys;  walk_y_o = xs;  walk_end_x_o = ye;  end
      ZONE2: begin walk_x_o = ys;  walk_y_o = -xs; walk_end_x_o = ye;  end
      ZONE3: begin walk_x_o = -xs; walk_y_o = ys;  walk_end_x_o = -xe; end
      ZONE4: begin walk_x_o = -xs; walk_y_o = -ys; walk_end_x_o = -xe; end
      ZONE5: begin walk_x_o = -ys; walk_y_o = -xs; walk_end_x_o = -ye; end
      ZONE6: begin walk_x_o = -ys; walk_y_o = xs;  walk_end_x_o = -ye; end
      ZONE7: begin walk_x_o = xs;  walk_y_o = -ys; walk_end_x_o = xe;  end
      default: begin walk_x_o = xs; walk_y_o = ys; walk_end_x_o = xe;  end
    endcase
  end

  // In zone 0, dx' is the larger magnitude and dy' the smaller
  assign major = x_major ? adx : ady;
  assign minor = x_major ? ady : adx;
  assign maj_w = signed'(DecW'(major));
  assign min_w = signed'(DecW'(minor));

  assign decision_o      = (min_w <<< 1) - maj_w;
  assign step_east_o     = min_w <<< 1;
  assign step_diagonal_o = (min_w - maj_w) <<< 1;
  assign active_o        = |major;

endmodule

[sv/octant_line_rasterizer.sv]
`timescale 1ns / 1ps
// Top level of the eight-zone midpoint line rasterizer.
//
// Usage: a start request (op_i = OP_START) loads a line from its two
// endpoints and produces no pixel. Each step request (op_i = OP_STEP)
// advances one pixel along the line and produces it, with last_pixel_o
// set on the end point. The start point itself is never produced, so a
// zero-length line produces nothing; steps with no line active are
// consumed silently. A new start replaces any line in progress.
// Channels: valid/stall on both sides; a request moves when valid is high
// and stall is low.
// Each pixel is registered in the main entry, or the skid entry on a stall.
// One request per cycle unless stalled; setup and the step update are each one
// pass of logic from the accepted request into the line and output registers.
// Output stall: a two-entry output (main register plus skid register) keeps
// the input open while one pixel waits; in_stall_o rises only once the skid
// register is occupied, and is driven from a register.
// Reset: rst_ni clears the line state (no line active) and both output
// entries; no clearing pass is needed.
module octant_line_rasterizer import olr_pkg::*; #(
  parameter int COORD_BITS = 12
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         op_i,
  input  logic signed [COORD_BITS-1:0] x_start_i,
  input  logic signed [COORD_BITS-1:0] y_start_i,
  input  logic signed [COORD_BITS-1:0] x_end_i,
  input  logic signed [COORD_BITS-1:0] y_end_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [COORD_BITS-1:0] pixel_x_o,
  output logic signed [COORD_BITS-1:0] pixel_y_o,
  output logic                         last_pixel_o
);

  localparam int WalkW = COORD_BITS + 1;
  localparam int DecW  = COORD_BITS + 3;

  // Line state (zone-0 space)
  logic signed [WalkW-1:0] walk_x_q, walk_y_q, walk_end_x_q;
  logic signed [DecW-1:0]  decision_q, step_east_q, step_diagonal_q;
  zone_e                   zone_q;
  logic                    active_q;

  // Setup results for a start request
  logic signed [WalkW-1:0] su_walk_x, su_walk_y, su_end_x;
  logic signed [DecW-1:0]  su_decision, su_step_east, su_step_diagonal;
  zone_e                   su_zone;
  logic                    su_active;

  // Step results
  logic signed [WalkW-1:0] wx_n, wy_n, px, py;
  logic signed [DecW-1:0]  dec_n;
  logic                    last_n;

  // Output main and skid entries
  logic                         out_valid_q, skid_valid_q;
  logic signed [COORD_BITS-1:0] out_x_q, out_y_q, skid_x_q, skid_y_q;
  logic                         out_last_q, skid_last_q;

  logic in_fire, step_fire, pix_valid;

  olr_setup #(
    .COORD_BITS(COORD_BITS)
  ) u_setup (
    .x_start_i      (x_start_i),
    .y_start_i      (y_start_i),
    .x_end_i        (x_end_i),
    .y_end_i        (y_end_i),
    .walk_x_o       (su_walk_x),
    .walk_y_o       (su_walk_y),
    .walk_end_x_o   (su_end_x),
    .decision_o     (su_decision),
    .step_east_o    (su_step_east),
    .step_diagonal_o(su_step_diagonal),
    .zone_o         (su_zone),
    .active_o       (su_active)
  );

  assign in_stall_o = skid_valid_q;
  assign in_fire    = in_valid_i && !skid_valid_q;
  assign step_fire  = in_fire && (op_i == OP_STEP);
  assign pix_valid  = step_fire && active_q;

  // One midpoint step; a tie takes the diagonal
  always_comb begin
    wx_n = walk_x_q + WalkW'(1);
    if (decision_q[DecW-1]) begin
      wy_n  = walk_y_q;
      dec_n = decision_q + step_east_q;
    end else begin
      wy_n  = walk_y_q + WalkW'(1);
      dec_n = decision_q + step_diagonal_q;
    end
    last_n = wx_n >= walk_end_x_q;
  end

  // Fold the new point back into the line's own zone
  always_comb begin
    unique case (zone_q)
      ZONE1:   begin px = wy_n;  py = wx_n;  end
      ZONE2:   begin px = -wy_n; py = wx_n;  end
      ZONE3:   begin px = -wx_n; py = wy_n;  end
      ZONE4:   begin px = -wx_n; py = -wy_n; end
      ZONE5:   begin px = -wy_n; py = -wx_n; end
      ZONE6:   begin px = wy_n;  py = -wx_n; end
      ZONE7:   begin px = wx_n;  py = -wy_n; end
      default: begin px = wx_n;  py = wy_n;  end
    endcase
  end

  // Line state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walk_x_q        <= '0;
      walk_y_q        <= '0;
      walk_end_x_q    <= '0;
      decision_q      <= '0;
      step_east_q     <= '0;
      step_diagonal_q <= '0;
      zone_q          <= ZONE0;
      active_q        <= 1'b0;
    end else if (in_fire) begin
      if (op_i == OP_START) begin
        walk_x_q        <= su_walk_x;
        walk_y_q        <= su_walk_y;
        walk_end_x_q    <= su_end_x;
        decision_q      <= su_decision;
        step_east_q     <= su_step_east;
        step_diagonal_q <= su_step_diagonal;
        zone_q          <= su_zone;
        active_q        <= su_active;
      end else if (active_q) begin
        walk_x_q   <= wx_n;
        walk_y_q   <= wy_n;
        decision_q <= dec_n;
        active_q   <= !last_n;
      end
    end
  end

  // Output register with skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || !out_stall_i) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= pix_valid;
      end
    end else if (pix_valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || !out_stall_i) begin
      if (skid_valid_q) begin
        out_x_q    <= skid_x_q;
        out_y_q    <= skid_y_q;
        out_last_q <= skid_last_q;
      end else if (pix_valid) begin
        out_x_q    <= px[COORD_BITS-1:0];
        out_y_q    <= py[COORD_BITS-1:0];
        out_last_q <= last_n;
      end
    end else if (pix_valid) begin
      skid_x_q    <= px[COORD_BITS-1:0];
      skid_y_q    <= py[COORD_BITS-1:0];
      skid_last_q <= last_n;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pixel_x_o    = out_x_q;
  assign pixel_y_o    = out_y_q;
  assign last_pixel_o = out_last_q;

endmodule
